>>> hdl/bev_pkg.sv
// Shared types and constants for the point-cloud BEV grid splatter.
// No dependencies; imported by bev_xform and point_cloud_bev_splatter.
`default_nettype none

package bev_pkg;

    localparam int COORD_W     = 10;
    localparam int IDX_W       = 11;
    localparam int CFG_W       = 48;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 64;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;

    localparam logic [1:0] REQ_SPLAT = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] CFG_ROW_X  = 2'd0;
    localparam logic [1:0] CFG_ROW_Y  = 2'd1;
    localparam logic [1:0] CFG_ROW_Z  = 2'd2;
    localparam logic [1:0] CFG_OFFSET = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] offset_xyz;
        logic [CFG_W-1:0] row_z;
        logic [CFG_W-1:0] row_y;
        logic [CFG_W-1:0] row_x;
    } bev_cfg_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [15:0]      height;
    } bev_pt_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_MEM,
        ST_PUSH
    } bev_state_t;

    typedef enum logic [2:0] {
        XS_IDLE,
        XS_MAC,
        XS_AXIS,
        XS_MUL,
        XS_QUO,
        XS_FIX,
        XS_DONE
    } bev_xs_t;

endpackage

`default_nettype wire

>>> hdl/bev_xform.sv
// Camera-to-world affine transform and grid binning, one shared 16x16 multiplier.
// Depends on bev_pkg (config and result structs, sequencer states).
`default_nettype none

module bev_xform
    import bev_pkg::*;
#(
    parameter int GRID_SIZE = 800,
    parameter int CELL_MM   = 50,
    parameter int COEF_FRAC = 13
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] cam_x,
    input  wire logic [15:0] cam_y,
    input  wire logic [15:0] cam_z,
    input  wire bev_cfg_t    cfg,
    output logic             done,
    output bev_pt_t          res
);

    localparam int     SPAN  = GRID_SIZE * CELL_MM;
    localparam int     BIAS  = (GRID_SIZE / 2) * CELL_MM;
    localparam int     VW    = $clog2(SPAN);
    localparam int     SH    = VW;
    localparam int     MW    = SH + 1;
    localparam int     PW    = VW + MW;
    localparam int     IW    = $clog2(GRID_SIZE);
    localparam int     AW    = 34;
    localparam int     WW    = 36;
    localparam longint RECIP = (longint'(1) << SH) / CELL_MM;
    localparam longint RND   = longint'(1) << (COEF_FRAC - 1);

    bev_xs_t state_reg, state_next;
    logic [1:0]           axis_reg;
    logic [1:0]           term_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [WW-1:0] v_reg;
    logic                 inr_reg;
    logic [PW-1:0]        p_reg;
    logic [IW-1:0]        q0_reg;
    logic [VW-1:0]        r_reg;
    logic [IW-1:0]        col_reg;
    logic [IW-1:0]        row_reg;
    logic                 hx_reg;
    logic                 hy_reg;
    logic [15:0]          height_reg;

    logic [CFG_W-1:0]     row_sel;
    logic signed [15:0]   coef_sel;
    logic signed [15:0]   cam_sel;
    logic signed [15:0]   off_sel;
    logic signed [31:0]   prod;
    logic signed [AW-1:0] acc_sum;
    logic signed [AW-1:0] acc_rnd;
    logic signed [AW-1:0] acc_sh;
    logic signed [WW-1:0] w;
    logic signed [WW-1:0] v_new;
    logic [15:0]          w_sat;
    logic [IW-1:0]        q0_w;
    logic [IW-1:0]        q_fix;

    // operand select
    always_comb
    begin
        case (axis_reg)
            2'd0:    row_sel = cfg.row_x;
            2'd1:    row_sel = cfg.row_y;
            default: row_sel = cfg.row_z;
        endcase
        case (axis_reg)
            2'd0:    off_sel = $signed(cfg.offset_xyz[15:0]);
            2'd1:    off_sel = $signed(cfg.offset_xyz[31:16]);
            default: off_sel = $signed(cfg.offset_xyz[47:32]);
        endcase
        case (term_reg)
            2'd0:
            begin
                coef_sel = $signed(row_sel[15:0]);
                cam_sel  = $signed(cam_x);
            end
            2'd1:
            begin
                coef_sel = $signed(row_sel[31:16]);
                cam_sel  = $signed(cam_y);
            end
            default:
            begin
                coef_sel = $signed(row_sel[47:32]);
                cam_sel  = $signed(cam_z);
            end
        endcase
    end

    assign prod    = coef_sel * cam_sel;
    assign acc_sum = ((term_reg == 2'd0) ? AW'(0) : acc_reg) + AW'(prod);
    assign acc_rnd = acc_reg + AW'(RND);
    assign acc_sh  = acc_rnd >>> COEF_FRAC;
    assign w       = WW'(acc_sh) + WW'(off_sel);
    // biased so that floor(v / CELL_MM) is the cell index directly
    assign v_new   = ((axis_reg == 2'd0) ? w : -w) + WW'(BIAS);

    always_comb
    begin
        if (w > WW'(32767))
            w_sat = 16'h7FFF;
        else if (w < -WW'(32768))
            w_sat = 16'h8000;
        else
            w_sat = w[15:0];
    end

    // reciprocal estimate is exact or one low
    assign q0_w  = p_reg[SH +: IW];
    assign q_fix = q0_reg + IW'(r_reg >= VW'(CELL_MM));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            XS_IDLE:
                if (start)
                    state_next = XS_MAC;
            XS_MAC:
                if (term_reg == 2'd2)
                    state_next = XS_AXIS;
            XS_AXIS:
                state_next = (axis_reg == 2'd2) ? XS_DONE : XS_MUL;
            XS_MUL:
                state_next = XS_QUO;
            XS_QUO:
                state_next = XS_FIX;
            XS_FIX:
                state_next = XS_MAC;
            XS_DONE:
                state_next = XS_IDLE;
            default:
                state_next = XS_IDLE;
        endcase
    end

    always_comb
    begin
        done       = (state_reg == XS_DONE);
        res.hit    = hx_reg & hy_reg;
        res.col    = res.hit ? IDX_W'(col_reg) : '0;
        res.row    = res.hit ? IDX_W'(row_reg) : '0;
        res.height = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= XS_IDLE;
            axis_reg  <= 2'd0;
            term_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                XS_IDLE:
                begin
                    axis_reg <= 2'd0;
                    term_reg <= 2'd0;
                end
                XS_MAC:
                    term_reg <= (term_reg == 2'd2) ? 2'd0 : term_reg + 2'd1;
                XS_FIX:
                    axis_reg <= axis_reg + 2'd1;
                default:
                    term_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            XS_MAC:
                acc_reg <= acc_sum;
            XS_AXIS:
            begin
                v_reg <= v_new;
                if (axis_reg == 2'd2)
                    height_reg <= w_sat;
            end
            XS_MUL:
            begin
                inr_reg <= (v_reg >= WW'(0)) && (v_reg < WW'(SPAN));
                p_reg   <= PW'(v_reg[VW-1:0]) * PW'(RECIP);
            end
            XS_QUO:
            begin
                q0_reg <= q0_w;
                r_reg  <= v_reg[VW-1:0] - VW'(q0_w * CELL_MM);
            end
            XS_FIX:
            begin
                if (axis_reg == 2'd0)
                begin
                    col_reg <= q_fix;
                    hx_reg  <= inr_reg;
                end
                else
                begin
                    row_reg <= q_fix;
                    hy_reg  <= inr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/point_cloud_bev_splatter.sv
// Splat: accepted item goes through the transform sequencer (with its single 16x16
// multiplier), then address, memory, output.
// Read: address, one-port grid memory, output. New frame: no result.
// One item in flight; the next is taken the cycle after the result is loaded.
// After reset the grid memory is swept to zero, all GRID_SIZE*GRID_SIZE cells
// (640000 by default); no item is accepted until then, config writes still are.
`default_nettype none

module point_cloud_bev_splatter
    import bev_pkg::*;
#(
    parameter int GRID_SIZE = 800,
    parameter int CELL_MM   = 50,
    parameter int COEF_FRAC = 13,
    parameter int TAG_BITS  = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // cam_x, cam_y, cam_z, red_in, green_in, blue_in, read_col, read_row, pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // cell_col, cell_row, cell_height, red_out, green_out, blue_out, pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // hit
    output logic [0:0]                  m_tuser,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    localparam int NCELL = GRID_SIZE * GRID_SIZE;
    localparam int AMW   = $clog2(NCELL);
    localparam int MEMW  = 40 + TAG_BITS;

    bev_state_t state_reg, state_next;
    bev_cfg_t   cfg_reg;
    bev_pt_t    xf_res;
    logic       xf_start;
    logic       xf_done;

    logic [1:0]          req_reg;
    logic [15:0]         cam_x_reg;
    logic [15:0]         cam_y_reg;
    logic [15:0]         cam_z_reg;
    logic [7:0]          red_reg;
    logic [7:0]          green_reg;
    logic [7:0]          blue_reg;
    logic [COORD_W-1:0]  rcol_reg;
    logic [COORD_W-1:0]  rrow_reg;
    logic [TAG_BITS-1:0] frame_reg;
    logic [AMW-1:0]      clr_reg;
    logic [AMW-1:0]      addr_reg;
    logic                rinr_reg;
    logic [MEMW-1:0]     mem_q_reg;
    logic [MEMW-1:0]     mem [NCELL];

    logic                m_tvalid_reg;
    logic                out_hit_reg;
    logic [COORD_W-1:0]  out_col_reg;
    logic [COORD_W-1:0]  out_row_reg;
    logic [15:0]         out_height_reg;
    logic [7:0]          out_red_reg;
    logic [7:0]          out_green_reg;
    logic [7:0]          out_blue_reg;

    logic                in_accept;
    logic                cfg_wr;
    logic                mem_we;
    logic [AMW-1:0]      mem_addr;
    logic [MEMW-1:0]     mem_wdata;
    logic                out_load;
    logic [IDX_W-1:0]    row_sel;
    logic [IDX_W-1:0]    col_sel;
    logic                out_hit;
    logic [COORD_W-1:0]  out_col;
    logic [COORD_W-1:0]  out_row;
    logic [15:0]         out_height;
    logic [7:0]          out_red;
    logic [7:0]          out_green;
    logic [7:0]          out_blue;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[4:3])
            CFG_ROW_X: prdata = APB_DW'(cfg_reg.row_x);
            CFG_ROW_Y: prdata = APB_DW'(cfg_reg.row_y);
            CFG_ROW_Z: prdata = APB_DW'(cfg_reg.row_z);
            default:   prdata = APB_DW'(cfg_reg.offset_xyz);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                CFG_ROW_X: cfg_reg.row_x      <= pwdata[CFG_W-1:0];
                CFG_ROW_Y: cfg_reg.row_y      <= pwdata[CFG_W-1:0];
                CFG_ROW_Z: cfg_reg.row_z      <= pwdata[CFG_W-1:0];
                default:   cfg_reg.offset_xyz <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    bev_xform #(
        .GRID_SIZE (GRID_SIZE),
        .CELL_MM   (CELL_MM),
        .COEF_FRAC (COEF_FRAC)
    ) u_xform (
        .clk   (clk),
        .rst_n (rst_n),
        .start (xf_start),
        .cam_x (cam_x_reg),
        .cam_y (cam_y_reg),
        .cam_z (cam_z_reg),
        .cfg   (cfg_reg),
        .done  (xf_done),
        .res   (xf_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == AMW'(NCELL - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                begin
                    case (s_tuser)
                        REQ_SPLAT: state_next = ST_CALC;
                        REQ_READ:  state_next = ST_ADDR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            ST_CALC:
                if (xf_done)
                    state_next = ST_ADDR;
            ST_ADDR:
                state_next = ST_MEM;
            ST_MEM:
                state_next = ST_PUSH;
            ST_PUSH:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        in_accept = s_tvalid & s_tready;
        xf_start  = in_accept && (s_tuser == REQ_SPLAT);
        mem_we    = (state_reg == ST_CLEAR) ||
                    ((state_reg == ST_MEM) && (req_reg == REQ_SPLAT) && xf_res.hit);
        out_load  = (state_reg == ST_PUSH) && (!m_tvalid_reg || m_tready);
    end

    assign mem_addr  = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 :
                       {frame_reg, xf_res.height, red_reg, green_reg, blue_reg};
    assign row_sel   = (req_reg == REQ_SPLAT) ? xf_res.row : IDX_W'(rrow_reg);
    assign col_sel   = (req_reg == REQ_SPLAT) ? xf_res.col : IDX_W'(rcol_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_q_reg <= mem[mem_addr];
    end

    // result select
    always_comb
    begin
        if (req_reg == REQ_SPLAT)
        begin
            out_hit    = xf_res.hit;
            out_col    = xf_res.col[COORD_W-1:0];
            out_row    = xf_res.row[COORD_W-1:0];
            out_height = xf_res.height;
            out_red    = red_reg;
            out_green  = green_reg;
            out_blue   = blue_reg;
        end
        else
        begin
            out_hit    = rinr_reg && (mem_q_reg[MEMW-1:40] == frame_reg);
            out_col    = rcol_reg;
            out_row    = rrow_reg;
            out_height = rinr_reg ? mem_q_reg[39:24] : 16'd0;
            out_red    = rinr_reg ? mem_q_reg[23:16] : 8'd0;
            out_green  = rinr_reg ? mem_q_reg[15:8]  : 8'd0;
            out_blue   = rinr_reg ? mem_q_reg[7:0]   : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            frame_reg    <= TAG_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AMW'(1);
            if (in_accept && (s_tuser == REQ_FRAME))
                frame_reg <= frame_reg + TAG_BITS'(1);
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg   <= s_tuser;
            cam_x_reg <= s_tdata[15:0];
            cam_y_reg <= s_tdata[31:16];
            cam_z_reg <= s_tdata[47:32];
            red_reg   <= s_tdata[55:48];
            green_reg <= s_tdata[63:56];
            blue_reg  <= s_tdata[71:64];
            rcol_reg  <= s_tdata[81:72];
            rrow_reg  <= s_tdata[91:82];
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= AMW'(row_sel * GRID_SIZE + col_sel);
            rinr_reg <= (rcol_reg < GRID_SIZE) && (rrow_reg < GRID_SIZE);
        end
        if (out_load)
        begin
            out_hit_reg    <= out_hit;
            out_col_reg    <= out_col;
            out_row_reg    <= out_row;
            out_height_reg <= out_height;
            out_red_reg    <= out_red;
            out_green_reg  <= out_green;
            out_blue_reg   <= out_blue;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {4'd0, out_blue_reg, out_green_reg, out_red_reg,
                       out_height_reg, out_row_reg, out_col_reg};

    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_tuser == REQ_FRAME)) |=>
            (frame_reg == $past(frame_reg) + TAG_BITS'(1)))
        else $error("frame tag did not advance");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        xf_done |-> (state_reg == ST_CALC))
        else $error("transform done outside calc");

    a_hit_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (xf_done && xf_res.hit) |-> ((xf_res.col < GRID_SIZE) && (xf_res.row < GRID_SIZE)))
        else $error("binned cell outside grid");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !m_tvalid_reg)
        else $error("result during clear sweep");

    a_push_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PUSH) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_PUSH))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

>>> dv/bev_grid_checker.sv
// Grid splatter checker: watches the config port and both item streams, keeps
// its own transform, grid stores and frame tag, and compares every result.
// Depends on bev_pkg for stream widths, request codes and register indexes.
`timescale 1ns / 1ps

module bev_grid_checker
    import bev_pkg::*;
#(
    parameter int GRID_SIZE = 800,
    parameter int CELL_MM   = 50,
    parameter int COEF_FRAC = 13
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]             m_tuser,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic                   pready,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output int                          fail_count,
    output int                          open_cells
);

    typedef struct packed {
        logic        hit;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [15:0] height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } cell_view_t;

    bev_cfg_t    xform;
    logic [23:0] colour_mem [int];
    logic [15:0] height_mem [int];
    logic [15:0] tag_mem [int];
    logic [15:0] frame_tag;
    cell_view_t  awaited_cells [$];
    int          mismatches;

    function automatic longint world_mm(input logic [47:0] coefs, input logic [15:0] offs,
                                        input logic signed [15:0] cx,
                                        input logic signed [15:0] cy,
                                        input logic signed [15:0] cz);
        longint acc;
        acc = longint'($signed(coefs[15:0])) * longint'(cx)
            + longint'($signed(coefs[31:16])) * longint'(cy)
            + longint'($signed(coefs[47:32])) * longint'(cz)
            + (longint'(1) <<< (COEF_FRAC - 1));
        return (acc >>> COEF_FRAC) + longint'($signed(offs));
    endfunction

    function automatic longint floor_cells(input longint mm);
        longint q;
        q = mm / CELL_MM;
        if ((mm % CELL_MM) != 0 && mm < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    task automatic take_request(input logic [1:0] req, input logic [IN_TDATA_W-1:0] d);
        logic signed [15:0] cx, cy, cz;
        longint             wx, wy, wz, col, row;
        int                 addr;
        cell_view_t         v;
        cx = d[15:0];
        cy = d[31:16];
        cz = d[47:32];
        v  = '0;
        case (req)
            REQ_SPLAT:
            begin
                wx = world_mm(xform.row_x, xform.offset_xyz[15:0], cx, cy, cz);
                wy = world_mm(xform.row_y, xform.offset_xyz[31:16], cx, cy, cz);
                wz = world_mm(xform.row_z, xform.offset_xyz[47:32], cx, cy, cz);
                col = GRID_SIZE / 2 + floor_cells(wx);
                row = GRID_SIZE / 2 + floor_cells(-wy);
                v.height = clamp16(wz);
                v.red    = d[55:48];
                v.green  = d[63:56];
                v.blue   = d[71:64];
                if (col >= 0 && col < GRID_SIZE && row >= 0 && row < GRID_SIZE)
                begin
                    addr = int'(row * GRID_SIZE + col);
                    colour_mem[addr] = {v.red, v.green, v.blue};
                    height_mem[addr] = v.height;
                    tag_mem[addr]    = frame_tag;
                    v.hit = 1'b1;
                    v.col = col[9:0];
                    v.row = row[9:0];
                end
                awaited_cells = {awaited_cells, v};
            end
            REQ_FRAME:
                frame_tag = frame_tag + 16'd1;
            REQ_READ:
            begin
                v.col = d[81:72];
                v.row = d[91:82];
                if (v.col < GRID_SIZE && v.row < GRID_SIZE)
                begin
                    addr = int'(v.row) * GRID_SIZE + int'(v.col);
                    if (colour_mem.exists(addr))
                    begin
                        v.hit = (tag_mem[addr] == frame_tag);
                        v.height = height_mem[addr];
                        {v.red, v.green, v.blue} = colour_mem[addr];
                    end
                    else
                    begin
                        // untouched cell: cleared store, tag zero
                        v.hit = (frame_tag == 16'd0);
                    end
                end
                awaited_cells = {awaited_cells, v};
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_view_t got, want;
        if (!rst_n)
        begin
            xform = '0;
            colour_mem.delete();
            height_mem.delete();
            tag_mem.delete();
            frame_tag = 16'd1;
            awaited_cells.delete();
            mismatches = 0;
            fail_count <= 0;
            open_cells <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:3])
                    CFG_ROW_X:  xform.row_x      = pwdata[CFG_W-1:0];
                    CFG_ROW_Y:  xform.row_y      = pwdata[CFG_W-1:0];
                    CFG_ROW_Z:  xform.row_z      = pwdata[CFG_W-1:0];
                    CFG_OFFSET: xform.offset_xyz = pwdata[CFG_W-1:0];
                    default:    ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.hit    = m_tuser[0];
                got.col    = m_tdata[9:0];
                got.row    = m_tdata[19:10];
                got.height = m_tdata[35:20];
                got.red    = m_tdata[43:36];
                got.green  = m_tdata[51:44];
                got.blue   = m_tdata[59:52];
                if (awaited_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected cell item hit=%0d col=%0d row=%0d", $time,
                                 got.hit, got.col, got.row);
                end
                else
                begin
                    want = awaited_cells.pop_front();
                    if (got.hit !== want.hit || got.col !== want.col || got.row !== want.row
                        || got.height !== want.height || got.red !== want.red
                        || got.green !== want.green || got.blue !== want.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: expected hit=%0d col=%0d row=%0d h=%0d rgb=%02x%02x%02x",
                                     $time, want.hit, want.col, want.row, $signed(want.height),
                                     want.red, want.green, want.blue);
                            $display("%0t: actual   hit=%0d col=%0d row=%0d h=%0d rgb=%02x%02x%02x",
                                     $time, got.hit, got.col, got.row, $signed(got.height),
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_request(s_tuser, s_tdata);
            fail_count <= mismatches;
            open_cells <= awaited_cells.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// Top of the grid splatter testbench: clock, reset, config writes, point,
// frame and read stimulus with random gaps, and the verdict.
// Depends on bev_pkg, point_cloud_bev_splatter and bev_grid_checker.
`timescale 1ns / 1ps

module tb_top;
    import bev_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 4_000_000;
    // camera z forward to world x, camera x to world -y, camera y down, 300 mm up
    localparam logic [47:0] BASE_ROW_X  = 48'h2000_0000_0000;
    localparam logic [47:0] BASE_ROW_Y  = 48'h0000_0000_E000;
    localparam logic [47:0] BASE_ROW_Z  = 48'h0000_E000_0000;
    localparam logic [47:0] BASE_OFFSET = 48'h012C_0000_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    int                     fail_count;
    int                     open_cells;
    int                     cycle_n = 0;
    logic                   calm;
    logic                   hold_go;

    point_cloud_bev_splatter i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    bev_grid_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .open_cells(open_cells)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        bit held;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    function automatic int spread(input int w);
        return int'($urandom_range(0, 2 * w)) - w;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] item_bits(
        input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz,
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
        input logic [9:0] rc, input logic [9:0] rr);
        return {4'b0, rr, rc, b, g, r, cz, cy, cx};
    endfunction

    // near-identity row: diagonal about +-1.0 in the given camera slot, small cross terms
    function automatic logic [47:0] tilted_row(input int slot);
        logic [47:0] r;
        r = {16'(spread(3000)), 16'(spread(3000)), 16'(spread(3000))};
        r[16*slot +: 16] = 16'(($urandom_range(0, 1) ? 8192 : -8192) + spread(1500));
        return r;
    endfunction

    task automatic offer(input logic [1:0] req, input logic [IN_TDATA_W-1:0] data);
        if (!calm && $urandom_range(0, 99) < 21)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_point(input int cx, input int cy, input int cz,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        offer(REQ_SPLAT, item_bits(16'(cx), 16'(cy), 16'(cz), r, g, b,
                                   10'($urandom), 10'($urandom)));
    endtask

    task automatic send_read(input int rc, input int rr);
        offer(REQ_READ, item_bits(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom), 10'(rc), 10'(rr)));
    endtask

    task automatic send_frame();
        offer(REQ_FRAME, {$urandom, $urandom, $urandom});
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [47:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_transform(input logic [47:0] rx, input logic [47:0] ry,
                                 input logic [47:0] rz, input logic [47:0] off);
        cfg_write(CFG_ROW_X, rx);
        cfg_write(CFG_ROW_Y, ry);
        cfg_write(CFG_ROW_Z, rz);
        cfg_write(CFG_OFFSET, off);
    endtask

    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_cells != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic random_item(output bit counted);
        int pick;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 55)
        begin
            if ($urandom_range(0, 3) == 0)
                send_point($urandom, $urandom, $urandom,
                           8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_point(spread(150), spread(2000), spread(150),
                           8'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (pick < 88)
        begin
            if ($urandom_range(0, 4) == 0)
                send_read($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                send_read($urandom_range(394, 406), $urandom_range(394, 406));
        end
        else if (pick < 96)
            send_frame();
        else
        begin
            offer(REQ_UNUSED, {$urandom, $urandom, $urandom});
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int  made, ph, quota;
        bit  counted;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_SPLAT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        hold_go  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // config is taken while the grid is still being cleared
        set_transform(BASE_ROW_X, BASE_ROW_Y, BASE_ROW_Z, BASE_OFFSET);

        send_point(0, 0, 0, 8'h00, 8'h00, 8'h00);
        send_point(0, -32768, -1, 8'hFF, 8'hFF, 8'hFF);   // height clips high, col 399
        send_point(-1, 32767, 49, 8'hA5, 8'h5A, 8'h3C);   // row 399, last mm of col 400
        send_point(0, 0, 50, 8'h01, 8'h80, 8'h7F);
        send_point(-20000, 0, -20000, 8'h12, 8'h34, 8'h56);
        send_point(19999, 0, 19999, 8'h9A, 8'hBC, 8'hDE);
        send_point(0, 0, 20000, 8'h55, 8'hAA, 8'h0F);     // one col past the edge
        send_point(20000, 0, 0, 8'hF0, 8'h0F, 8'h33);     // one row past the edge
        send_point(32767, 0, -32768, 8'hC3, 8'h3C, 8'h99);
        send_read(400, 400);
        send_read(0, 0);
        send_read(799, 799);
        send_read(5, 5);                                  // never written
        send_read(800, 0);
        send_read(0, 1023);
        send_frame();
        send_read(400, 400);                              // stale after new frame
        offer(REQ_UNUSED, {$urandom, $urandom, $urandom});
        send_point(0, 0, 0, 8'h77, 8'h66, 8'h55);
        send_read(400, 400);

        // near-corner cell, read in its own frame and after the next one
        send_point(-19500, 0, -19500, 8'h11, 8'h22, 8'h33);
        send_read(10, 10);
        send_read(0, 0);
        send_frame();
        send_read(10, 10);

        for (ph = 0; ph < 6; ph++)
        begin
            settle(32);
            case (ph)
                1: set_transform('1, '1, '1, '1);
                2: set_transform(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
                                 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000);
                4: set_transform('0, '0, '0, '0);
                default: set_transform(tilted_row(2), tilted_row(0), tilted_row(1),
                                       {16'($urandom), 16'(spread(200)), 16'(spread(200))});
            endcase
            case (ph)
                0: quota = 400;
                3: quota = 300;
                4: quota = 30;
                5: quota = 200;
                default: quota = 60;
            endcase
            made = 0;
            while (made < quota)
            begin
                calm <= (ph == 3 && made < 150);
                if (ph == 0 && made == 120)
                    hold_go <= 1'b1;
                random_item(counted);
                made += counted;
            end
        end

        settle(40);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bev_pkg.sv
hdl/bev_xform.sv
hdl/point_cloud_bev_splatter.sv
dv/bev_grid_checker.sv
dv/tb_top.sv
